// ----- sv/bpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int unsigned MemWordsDefault    = 1024;
  localparam int unsigned MaxElementsDefault = 32768;
  localparam int unsigned CfgAddrW           = 3;
  localparam logic [5:0]  ElemBitsReset      = 6'd8;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_APPEND = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    REG_ELEM_BITS  = 1'b0,
    REG_AUTO_WIDEN = 1'b1
  } reg_e;

  typedef struct packed {
    req_e        req_type;
    logic [14:0] elem_index;
    logic [31:0] elem_value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    status_e     status;
    logic [5:0]  width_now;
    logic [15:0] element_total;
  } rsp_t;

  typedef struct packed {
    logic       elem_bits_wr;
    logic [5:0] elem_bits_wdata;
    logic       auto_widen;
  } cfg_t;

  function automatic logic [31:0] width_mask(input logic [5:0] w);
    logic [32:0] m;
    m = (33'd1 << w) - 33'd1;
    if (w >= 6'd32) begin
      return 32'hFFFF_FFFF;
    end
    return m[31:0];
  endfunction

  function automatic logic [5:0] clamp_width(input logic [5:0] v);
    if (v == 6'd0) begin
      return 6'd1;
    end
    if (v > 6'd32) begin
      return 6'd32;
    end
    return v;
  endfunction

  function automatic logic [5:0] bit_length(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] extract(input logic [63:0] pair, input logic [4:0] off,
                                          input logic [5:0] w);
    logic [63:0] sh;
    sh = pair >> off;
    return sh[31:0] & width_mask(w);
  endfunction

  function automatic logic [63:0] merge(input logic [63:0] pair, input logic [4:0] off,
                                        input logic [5:0] w, input logic [31:0] v);
    logic [63:0] m;
    logic [63:0] d;
    m = {32'd0, width_mask(w)} << off;
    d = {32'd0, v & width_mask(w)} << off;
    return (pair & ~m) | d;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bit_packed_array_access_core.sv -----
// Packed array of unsigned elements held in two 32-bit word banks (even and odd words).
// Input channel: one request word per accepted transfer (read, write at an index, append, or none).
// Output channel: exactly one result word per request, in request order.
// Configuration: APB registers element_bits (writing it empties the store) and auto_widen.
// An ordinary request passes through states DECIDE and ACC to the registered result, and the
// next request is taken in the cycle after the result is loaded, so a new request is only
// taken once the last one is done. The cost is set by one registered bank read followed by
// the read-modify-write of one or two words in state ACC.
// A widening request first repacks every stored element from the highest index down, in
// the steps offset compute, old read, new read and write, then recomputes its own position.
// Reset empties the store, sets the width to 8 and auto widening off; the word banks
// are not cleared, since only stored elements are ever read.
// While the receiver stalls, the result register holds its word; the block can accept
// and work on one more request, which then waits for the result register to free up.
`timescale 1ns / 1ps
`default_nettype none

module bit_packed_array_access_core #(
  parameter int unsigned MEM_WORDS    = bpa_pkg::MemWordsDefault,
  parameter int unsigned MAX_ELEMENTS = bpa_pkg::MaxElementsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bpa_pkg::req_t                in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bpa_pkg::rsp_t                out_word_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpa_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned AddrW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned CntW      = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned NeedW     = CntW + 1;
  localparam int unsigned OpW       = (CntW > 15) ? CntW : 15;
  localparam int unsigned PosW      = OpW + 6;
  localparam int unsigned CapW      = ((NeedW + 6) > (AddrW + 7)) ? (NeedW + 6) : (AddrW + 7);
  localparam int unsigned EvenDepth = (MEM_WORDS + 1) / 2;
  localparam int unsigned OddDepth  = MEM_WORDS / 2;
  localparam int unsigned EvenAw    = (EvenDepth > 1) ? $clog2(EvenDepth) : 1;
  localparam int unsigned OddAw     = (OddDepth > 1) ? $clog2(OddDepth) : 1;
  localparam logic [CapW-1:0]    CapBits = CapW'(MEM_WORDS * 32);
  localparam logic [NeedW-1:0]   MaxCnt  = NeedW'(MAX_ELEMENTS);
  localparam logic [AddrW:0]     WordLim = (AddrW + 1)'(MEM_WORDS);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CALC      = 8'b0000_0010,
    S_DECIDE    = 8'b0000_0100,
    S_ACC       = 8'b0000_1000,
    S_RP_CALC   = 8'b0001_0000,
    S_RP_RD_OLD = 8'b0010_0000,
    S_RP_RD_NEW = 8'b0100_0000,
    S_RP_WR     = 8'b1000_0000
  } state_e;

  bpa_pkg::cfg_t cfg;

  state_e state_q, state_d;
  bpa_pkg::req_t req_q;
  logic [5:0] width_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] rp_i_q;
  logic [PosW-1:0] pos_q, rp_old_q, rp_new_q;
  logic [CapW-1:0] cap_cur_q, cap_new_q;
  logic [5:0] bl_q;
  bpa_pkg::status_e status_q, st_d;
  logic [31:0] elem_q;
  logic sel_q;
  logic out_valid_q;
  bpa_pkg::rsp_t out_q;

  logic in_accept;
  bpa_pkg::req_t src;
  logic src_app, req_app;
  logic [OpW-1:0] tgt;
  logic [NeedW-1:0] needed_c, needed_r;
  logic [5:0] bl_c;
  logic [PosW-1:0] pos_c;
  logic [CapW-1:0] cap_cur_c, cap_new_c;
  logic calc_en, st_en, rp_start, rp_step, rp_done, grab_elem, finish;
  logic range_bad, widen, cur_full, new_full;
  logic [CntW-1:0] rp_dec;

  logic [PosW-1:0] cur_pos;
  logic [AddrW-1:0] wa;
  logic [AddrW:0] wa_inc;
  logic [4:0] off;
  logic [5:0] wr_w;
  logic two, mem_ok, mem_wr;
  logic [31:0] even_rd, odd_rd, lo, hi, wr_val;
  logic [63:0] pair, new_pair;
  logic even_we, odd_we;
  logic [31:0] even_wd, odd_wd;
  logic [EvenAw-1:0] even_row;
  logic [OddAw-1:0] odd_row;
  logic [CntW-1:0] cnt_next;

  bpa_apb u_apb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign src       = (state_q == S_IDLE) ? in_word_i : req_q;
  assign src_app   = (src.req_type == bpa_pkg::REQ_APPEND);
  assign req_app   = (req_q.req_type == bpa_pkg::REQ_APPEND);
  assign tgt       = src_app ? OpW'(count_q) : OpW'(src.elem_index);
  assign needed_c  = NeedW'(count_q) + (src_app ? NeedW'(1) : NeedW'(0));
  assign needed_r  = NeedW'(count_q) + (req_app ? NeedW'(1) : NeedW'(0));
  assign bl_c      = bpa_pkg::bit_length(src.elem_value);
  assign pos_c     = PosW'(tgt) * PosW'(width_q);
  assign cap_cur_c = (CapW'(count_q) + CapW'(1)) * CapW'(width_q);
  assign cap_new_c = CapW'(needed_c) * CapW'(bl_c);

  assign range_bad = OpW'(req_q.elem_index) >= OpW'(count_q);
  assign widen     = cfg.auto_widen && (bl_q > width_q);
  assign cur_full  = !(((NeedW'(count_q) + NeedW'(1)) <= MaxCnt) && (cap_cur_q <= CapBits));
  assign new_full  = !((needed_r <= MaxCnt) && (cap_new_q <= CapBits));
  assign rp_dec    = rp_i_q - CntW'(1);

  always_comb begin
    state_d   = state_q;
    calc_en   = 1'b0;
    st_en     = 1'b0;
    st_d      = bpa_pkg::STATUS_OK;
    rp_start  = 1'b0;
    rp_step   = 1'b0;
    rp_done   = 1'b0;
    grab_elem = 1'b0;
    finish    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          calc_en = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_CALC: begin
        calc_en = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        st_en   = 1'b1;
        state_d = S_ACC;
        unique case (req_q.req_type)
          bpa_pkg::REQ_READ: begin
            if (range_bad) st_d = bpa_pkg::STATUS_RANGE;
          end
          bpa_pkg::REQ_WRITE: begin
            if (range_bad) begin
              st_d = bpa_pkg::STATUS_RANGE;
            end else if (widen) begin
              if (new_full) begin
                st_d = bpa_pkg::STATUS_FULL;
              end else begin
                rp_start = 1'b1;
                state_d  = S_RP_CALC;
              end
            end
          end
          bpa_pkg::REQ_APPEND: begin
            if (cur_full) begin
              st_d = bpa_pkg::STATUS_FULL;
            end else if (widen) begin
              if (new_full) begin
                st_d = bpa_pkg::STATUS_FULL;
              end else begin
                rp_start = 1'b1;
                state_d  = S_RP_CALC;
              end
            end
          end
          default: ;
        endcase
      end
      S_ACC: begin
        if (!out_valid_q || !out_stall_i) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RP_CALC: begin
        if (rp_i_q == '0) begin
          rp_done = 1'b1;
          state_d = S_CALC;
        end else begin
          rp_step = 1'b1;
          state_d = S_RP_RD_OLD;
        end
      end
      S_RP_RD_OLD: state_d = S_RP_RD_NEW;
      S_RP_RD_NEW: begin
        grab_elem = 1'b1;
        state_d   = S_RP_WR;
      end
      S_RP_WR: state_d = S_RP_CALC;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_RP_RD_OLD:          cur_pos = rp_old_q;
      S_RP_RD_NEW, S_RP_WR: cur_pos = rp_new_q;
      default:              cur_pos = pos_q;
    endcase
  end

  assign wa       = cur_pos[AddrW+4:5];
  assign off      = cur_pos[4:0];
  assign wa_inc   = (AddrW + 1)'(wa) + (AddrW + 1)'(1);
  assign even_row = EvenAw'(wa_inc >> 1);
  assign odd_row  = OddAw'(wa >> 1);
  assign wr_w     = (state_q == S_RP_WR) ? bl_q : width_q;
  assign two      = ((7'(off) + 7'(wr_w)) > 7'd32) && (wa_inc < WordLim);

  assign lo       = sel_q ? odd_rd : even_rd;
  assign hi       = sel_q ? even_rd : odd_rd;
  assign pair     = {hi, lo};
  assign wr_val   = (state_q == S_RP_WR) ? elem_q : req_q.elem_value;
  assign new_pair = bpa_pkg::merge(pair, off, wr_w, wr_val);

  assign mem_ok  = (status_q == bpa_pkg::STATUS_OK);
  assign mem_wr  = (finish && mem_ok && ((req_q.req_type == bpa_pkg::REQ_WRITE) || req_app))
                   || (state_q == S_RP_WR);
  assign even_we = mem_wr && (!wa[0] || two);
  assign odd_we  = mem_wr && (wa[0] || two);
  assign even_wd = wa[0] ? new_pair[63:32] : new_pair[31:0];
  assign odd_wd  = wa[0] ? new_pair[31:0] : new_pair[63:32];

  bpa_ram #(.Depth(EvenDepth)) u_even (
    .clk_i  (clk_i),
    .we_i   (even_we),
    .addr_i (even_row),
    .wdata_i(even_wd),
    .rdata_o(even_rd)
  );

  bpa_ram #(.Depth(OddDepth)) u_odd (
    .clk_i  (clk_i),
    .we_i   (odd_we),
    .addr_i (odd_row),
    .wdata_i(odd_wd),
    .rdata_o(odd_rd)
  );

  assign cnt_next = count_q + ((mem_ok && req_app) ? CntW'(1) : CntW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= bpa_pkg::ElemBitsReset;
      count_q     <= '0;
      rp_i_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg.elem_bits_wr) begin
        width_q <= cfg.elem_bits_wdata;
        count_q <= '0;
      end else begin
        if (rp_done) width_q <= bl_q;
        if (finish) count_q <= cnt_next;
      end
      if (rp_start) begin
        rp_i_q <= count_q;
      end else if (rp_step) begin
        rp_i_q <= rp_dec;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= wa[0];
    if (in_accept) req_q <= in_word_i;
    if (calc_en) begin
      pos_q     <= pos_c;
      cap_cur_q <= cap_cur_c;
      cap_new_q <= cap_new_c;
      bl_q      <= bl_c;
    end
    if (st_en) status_q <= st_d;
    if (rp_step) begin
      rp_old_q <= PosW'(rp_dec) * PosW'(width_q);
      rp_new_q <= PosW'(rp_dec) * PosW'(bl_q);
    end
    if (grab_elem) elem_q <= bpa_pkg::extract(pair, rp_old_q[4:0], width_q);
    if (finish) begin
      out_q.read_value    <= (mem_ok && (req_q.req_type == bpa_pkg::REQ_READ))
                             ? bpa_pkg::extract(pair, pos_q[4:0], width_q) : 32'd0;
      out_q.status        <= status_q;
      out_q.width_now     <= width_q;
      out_q.element_total <= 16'(cnt_next);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NeedW'(count_q) <= MaxCnt)
    else $error("element count exceeds capacity");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q >= 6'd1) && (width_q <= 6'd32))
    else $error("element width out of range");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (even_we || odd_we) |-> ((state_q == S_ACC) || (state_q == S_RP_WR)))
    else $error("bank write outside an update state");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ACC) && out_valid_q && out_stall_i) |=> (state_q == S_ACC))
    else $error("request finished while result register was blocked");

  a_repack_wider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RP_WR) |-> (bl_q > width_q))
    else $error("repack without a wider target width");

endmodule

`default_nettype wire

// ----- sv/bpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
  parameter int unsigned Depth = 512
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [31:0]                               wdata_i,
  output logic [31:0]                               rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/bpa_apb.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpa_apb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpa_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bpa_pkg::cfg_t                 cfg_o
);

  logic          wr;
  bpa_pkg::reg_e idx;
  logic [5:0]    elem_bits_q;
  logic          auto_widen_q;

  assign wr     = psel && penable && pwrite;
  assign idx    = bpa_pkg::reg_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bits_q  <= bpa_pkg::ElemBitsReset;
      auto_widen_q <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        bpa_pkg::REG_ELEM_BITS:  elem_bits_q  <= bpa_pkg::clamp_width(pwdata[5:0]);
        bpa_pkg::REG_AUTO_WIDEN: auto_widen_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bpa_pkg::REG_ELEM_BITS:  prdata = {26'd0, elem_bits_q};
      bpa_pkg::REG_AUTO_WIDEN: prdata = {31'd0, auto_widen_q};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.elem_bits_wr    = wr && (idx == bpa_pkg::REG_ELEM_BITS);
  assign cfg_o.elem_bits_wdata = bpa_pkg::clamp_width(pwdata[5:0]);
  assign cfg_o.auto_widen      = auto_widen_q;

endmodule

`default_nettype wire

// ----- tb/bit_packed_array_access_core_tb.sv -----
`timescale 1ns / 1ps

module bit_packed_array_access_core_tb;

  localparam int unsigned MemWords    = 1024;
  localparam int unsigned MaxElems    = 32768;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandomItems = 852;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  bpa_pkg::req_t                in_word_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  bpa_pkg::rsp_t                out_word_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bpa_pkg::CfgAddrW-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  bit_packed_array_access_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow copy of the packed store and its registers.
  logic [31:0]   shadow_words [MemWords];
  logic [15:0]   shadow_count;
  logic [5:0]    shadow_width;
  logic          shadow_widen;
  bpa_pkg::rsp_t expected_words [$];
  bpa_pkg::rsp_t last_pred;

  int            mismatches;
  int            directed_errors;
  int            idle_cycles;
  int            out_idle_pct;
  bit            hold_out;
  bit            sink_long_hold;

  typedef struct {
    bpa_pkg::req_e kind;
    logic [14:0]   index;
    logic [31:0]   value;
    bit            typed;
    bpa_pkg::rsp_t result;
  } row_t;

  function automatic logic [31:0] lmask(input logic [5:0] w);
    return (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
  endfunction

  function automatic logic [5:0] msb_len(input logic [31:0] v);
    logic [5:0] n;
    n = 0;
    for (int i = 0; i < 32; i++) if (v[i]) n = 6'(i + 1);
    return n;
  endfunction

  function automatic bit room_for(input longint n, input logic [5:0] w);
    return n <= MaxElems && n * w <= longint'(MemWords) * 32;
  endfunction

  function automatic logic [31:0] elem_get(input longint idx, input logic [5:0] w);
    longint      pos;
    longint      wi;
    logic [63:0] pair;
    pos = idx * w;
    wi = pos >> 5;
    if (wi >= MemWords) return 0;
    pair = {32'd0, shadow_words[wi]};
    if ((pos % 32) + w > 32 && wi + 1 < MemWords) pair[63:32] = shadow_words[wi + 1];
    return 32'(pair >> (pos % 32)) & lmask(w);
  endfunction

  function automatic void elem_put(input longint idx, input logic [5:0] w,
                                   input logic [31:0] v);
    longint      pos;
    longint      wi;
    logic [63:0] pair;
    logic [63:0] m;
    bit          two;
    pos = idx * w;
    wi = pos >> 5;
    if (wi >= MemWords) return;
    two = ((pos % 32) + w > 32) && (wi + 1 < MemWords);
    pair = {32'd0, shadow_words[wi]};
    if (two) pair[63:32] = shadow_words[wi + 1];
    m = {32'd0, lmask(w)} << (pos % 32);
    pair = (pair & ~m) | ({32'd0, v & lmask(w)} << (pos % 32));
    shadow_words[wi] = pair[31:0];
    if (two) shadow_words[wi + 1] = pair[63:32];
  endfunction

  function automatic bit widen_for(input logic [31:0] v, input longint needed);
    logic [5:0] nw;
    nw = msb_len(v);
    if (!shadow_widen || nw <= shadow_width) return 1;
    if (!room_for(needed, nw)) return 0;
    for (longint i = shadow_count; i > 0; i--) begin
      elem_put(i - 1, nw, elem_get(i - 1, shadow_width));
    end
    shadow_width = nw;
    return 1;
  endfunction

  function automatic bpa_pkg::rsp_t access_result(input bpa_pkg::req_t r);
    bpa_pkg::rsp_t o;
    o = '0;
    o.status = bpa_pkg::STATUS_OK;
    case (r.req_type)
      bpa_pkg::REQ_READ: begin
        if (r.elem_index >= shadow_count) o.status = bpa_pkg::STATUS_RANGE;
        else o.read_value = elem_get(r.elem_index, shadow_width);
      end
      bpa_pkg::REQ_WRITE: begin
        if (r.elem_index >= shadow_count) o.status = bpa_pkg::STATUS_RANGE;
        else if (!widen_for(r.elem_value, shadow_count)) o.status = bpa_pkg::STATUS_FULL;
        else elem_put(r.elem_index, shadow_width, r.elem_value);
      end
      bpa_pkg::REQ_APPEND: begin
        if (!room_for(shadow_count + 1, shadow_width)) o.status = bpa_pkg::STATUS_FULL;
        else if (!widen_for(r.elem_value, shadow_count + 1)) o.status = bpa_pkg::STATUS_FULL;
        else begin
          elem_put(shadow_count, shadow_width, r.elem_value);
          shadow_count++;
        end
      end
      default: ;
    endcase
    o.width_now = shadow_width;
    o.element_total = shadow_count;
    return o;
  endfunction

  always #4 clk_i = ~clk_i;

  // Result checker and receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: actual %p", $time, out_word_o);
        mismatches++;
      end else begin
        if (out_word_o.read_value !== expected_words[0].read_value ||
            out_word_o.status !== expected_words[0].status ||
            out_word_o.width_now !== expected_words[0].width_now ||
            out_word_o.element_total !== expected_words[0].element_total) begin
          $display("%0t mismatch: expected %p actual %p", $time, expected_words[0],
                   out_word_o);
          mismatches++;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_out) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  always @(posedge sink_long_hold) begin
    hold_out = 1;
    repeat (300) @(negedge clk_i);
    hold_out = 0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(input bpa_pkg::reg_e which, input logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {which, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (which == bpa_pkg::REG_ELEM_BITS) begin
      shadow_width = (v[5:0] == 0) ? 6'd1 : (v[5:0] > 32) ? 6'd32 : v[5:0];
      shadow_count = 0;
    end else shadow_widen = v[0];
  endtask

  // The valid stays high into the next word unless a gap is drawn.
  task automatic send(input bpa_pkg::req_t r, input int gap_pct);
    in_valid_i <= 1;
    in_word_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    last_pred = access_result(r);
    expected_words = {expected_words, last_pred};
    @(negedge clk_i);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 0;
      do @(negedge clk_i); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic bpa_pkg::req_t rand_req(input int appends_pct);
    bpa_pkg::req_t r;
    int            pick;
    int            vb;
    pick = $urandom_range(99);
    r.req_type = (pick < appends_pct) ? bpa_pkg::REQ_APPEND :
                 (pick < 90) ? bpa_pkg::req_e'($urandom_range(1))
                             : bpa_pkg::req_e'($urandom_range(3));
    if (shadow_count != 0 && $urandom_range(9) != 0)
      r.elem_index = 15'($urandom_range(shadow_count - 1));
    else r.elem_index = 15'($urandom);
    vb = $urandom_range(32);
    r.elem_value = (vb == 0) ? 32'd0 : ($urandom & lmask(6'(vb)));
    return r;
  endfunction

  row_t directed [9] = '{
    '{bpa_pkg::REQ_READ,   15'd0,    32'd0,         1,
      '{32'd0,   bpa_pkg::STATUS_RANGE, 6'd8, 16'd0}},
    '{bpa_pkg::REQ_WRITE,  15'd0,    32'd5,         1,
      '{32'd0,   bpa_pkg::STATUS_RANGE, 6'd8, 16'd0}},
    '{bpa_pkg::REQ_NONE,   15'h7FFF, 32'hFFFF_FFFF, 1,
      '{32'd0,   bpa_pkg::STATUS_OK,    6'd8, 16'd0}},
    '{bpa_pkg::REQ_APPEND, 15'd0,    32'hFFFF_FFFF, 1,
      '{32'd0,   bpa_pkg::STATUS_OK,    6'd8, 16'd1}},
    '{bpa_pkg::REQ_READ,   15'd0,    32'd0,         1,
      '{32'd255, bpa_pkg::STATUS_OK,    6'd8, 16'd1}},
    '{bpa_pkg::REQ_APPEND, 15'd0,    32'h5A,        0, '0},
    '{bpa_pkg::REQ_WRITE,  15'd1,    32'h1A5,       0, '0},
    '{bpa_pkg::REQ_READ,   15'd1,    32'd0,         0, '0},
    '{bpa_pkg::REQ_READ,   15'h7FFF, 32'd0,         1,
      '{32'd0,   bpa_pkg::STATUS_RANGE, 6'd8, 16'd2}}
  };

  initial begin
    bpa_pkg::req_t r;
    rst_ni = 0; in_valid_i = 0; in_word_i = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    out_idle_pct = 34;
    shadow_count = 0; shadow_width = bpa_pkg::ElemBitsReset; shadow_widen = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;

    foreach (directed[k]) begin
      r.req_type = directed[k].kind;
      r.elem_index = directed[k].index;
      r.elem_value = directed[k].value;
      send(r, 34);
      if (directed[k].typed && last_pred !== directed[k].result) begin
        $display("%0t directed row %0d: expected %p model %p", $time, k,
                 directed[k].result, last_pred);
        directed_errors++;
      end
    end
    drain();

    // Auto-widen from narrow widths, including straddling values.
    reg_write(bpa_pkg::REG_ELEM_BITS, 32'd0);
    reg_write(bpa_pkg::REG_AUTO_WIDEN, 32'd1);
    for (int k = 0; k < 12; k++) begin
      r.req_type = bpa_pkg::REQ_APPEND; r.elem_index = 15'd0;
      r.elem_value = 32'd1 << (k * 3);
      send(r, 34);
    end
    r.req_type = bpa_pkg::REQ_WRITE; r.elem_index = 15'd3; r.elem_value = 32'hFFFF_FFFF;
    send(r, 0);
    drain();

    // Fill a 32-bit store to capacity, then hit the full case.
    reg_write(bpa_pkg::REG_ELEM_BITS, 32'd63);
    reg_write(bpa_pkg::REG_AUTO_WIDEN, 32'd0);
    for (int k = 0; k < MemWords + 2; k++) begin
      r.req_type = bpa_pkg::REQ_APPEND; r.elem_index = 15'd0; r.elem_value = $urandom;
      send(r, 0);
    end
    r.req_type = bpa_pkg::REQ_READ; r.elem_index = 15'(MemWords - 1); r.elem_value = 32'd0;
    send(r, 0);
    drain();

    // Random phases across several widths; one phase has no idling at all.
    for (int phase = 0; phase < 6; phase++) begin
      reg_write(bpa_pkg::REG_ELEM_BITS, (phase == 0) ? 32'd1 : $urandom_range(1, 40));
      reg_write(bpa_pkg::REG_AUTO_WIDEN, 32'(phase % 2));
      out_idle_pct = (phase == 2) ? 0 : 34;
      if (phase == 3) sink_long_hold = 1;
      for (int k = 0; k < RandomItems / 6; k++) begin
        send(rand_req(shadow_count < 40 ? 60 : 25), (phase == 2) ? 0 : 34);
        if (phase == 4 && k == 100) drain();
      end
      sink_long_hold = 0;
      drain();
    end

    drain();
    if (mismatches == 0 && directed_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_apb.sv
sv/bit_packed_array_access_core.sv
tb/bit_packed_array_access_core_tb.sv
